// File: rtl/gradient_color_lookup_top_defines.svh
// ---------------------------------------------------------------------------
// Gradient color lookup: assertion macros
// Clocked assertion shorthands shared by the gradient color lookup RTL.
// ---------------------------------------------------------------------------
`ifndef GRADIENT_COLOR_LOOKUP_TOP_DEFINES_SVH
`define GRADIENT_COLOR_LOOKUP_TOP_DEFINES_SVH

// same-cycle implication
`define GCL_CHECK_SAME(name, cond, conseq, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (conseq)) \
      else $error(msg);

// next-cycle implication
`define GCL_CHECK_NEXT(name, cond, conseq, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
      else $error(msg);

`endif

// File: rtl/gcl_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Gradient color lookup package
// Widths, word types and codes shared by the gradient lookup pipeline.
// ---------------------------------------------------------------------------
package gcl_pkg;

   localparam int CHAN_W     = 12;
   localparam int POS_W      = 16;
   localparam int NUM_CHAN   = 4;
   localparam int CNT_W      = 3;
   localparam int STOP_W     = 64;
   localparam int CSR_IDX_W  = 3;
   localparam int PROD_W     = CHAN_W + POS_W;
   localparam int QUOT_W     = CHAN_W;
   localparam int QUOT_STEPS = 2;
   localparam int DIV_STAGES = QUOT_W / QUOT_STEPS;
   localparam int NUM_STAGES = DIV_STAGES + 4;

   // channel slots inside a color word
   localparam int CH_RED   = 3;
   localparam int CH_GREEN = 2;
   localparam int CH_BLUE  = 1;
   localparam int CH_ALPHA = 0;

   // register indexes
   localparam int REG_STOP_COUNT = 0;
   localparam int REG_STOP_FIRST = 1;

   typedef logic [CHAN_W-1:0] chan_type;
   typedef logic [POS_W-1:0]  pos_type;
   typedef logic [PROD_W-1:0] prod_type;
   typedef chan_type [NUM_CHAN-1:0] color_type;

   typedef struct packed {
      pos_type   pos;
      color_type color;
   } stop_type;

   typedef struct packed {
      logic      bypass;
      pos_type   p;
      pos_type   pl;
      pos_type   pr;
      color_type cl;
      color_type cr;
   } seg_type;

   typedef struct packed {
      logic                bypass;
      color_type           base;
      logic [NUM_CHAN-1:0] neg;
   } side_type;

   typedef struct packed {
      side_type  side;
      color_type mag;
      pos_type   dp;
      pos_type   span;
   } prep_type;

   typedef struct packed {
      side_type                 side;
      prod_type [NUM_CHAN-1:0]  rem;
      color_type                quot;
      pos_type                  span;
   } div_type;

   localparam color_type COLOR_BLACK = '{CH_RED: '0, CH_GREEN: '0, CH_BLUE: '0,
                                         CH_ALPHA: '1};

endpackage

// File: rtl/gcl_select.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Gradient segment select
// Finds the stop pair around the position, or the clamped color, and
// registers the segment word.
// ---------------------------------------------------------------------------
module gcl_select #(
   parameter int MAX_STOPS = 7
) (
   input  logic                                 clock,
   input  logic                                 load,
   input  gcl_pkg::pos_type                     position,
   input  logic [gcl_pkg::CNT_W-1:0]            stop_count,
   input  gcl_pkg::stop_type [MAX_STOPS-1:0]    stops,
   output gcl_pkg::seg_type                     seg_o
);
   import gcl_pkg::*;

   logic [CNT_W-1:0]     n_sat;
   logic [MAX_STOPS-1:0] right_oh;
   logic                 found;
   color_type            cl_pick;
   color_type            cr_pick;
   color_type            last_pick;
   pos_type              pl_pick;
   pos_type              pr_pick;
   seg_type              seg_in;
   seg_type              seg_ff;

   assign n_sat = (stop_count > CNT_W'(MAX_STOPS)) ? CNT_W'(MAX_STOPS) : stop_count;

   // first stop after stop 0 that is at or beyond the position
   always_comb begin
      right_oh = '0;
      found    = 1'b0;
      for (int k = MAX_STOPS - 1; k >= 1; k--) begin
         if ((CNT_W'(k) < n_sat) && (position <= stops[k].pos)) begin
            right_oh    = '0;
            right_oh[k] = 1'b1;
            found       = 1'b1;
         end
      end
   end

   always_comb begin
      cl_pick   = '0;
      cr_pick   = '0;
      last_pick = '0;
      pl_pick   = '0;
      pr_pick   = '0;
      for (int k = 0; k < MAX_STOPS; k++) begin
         cr_pick   = cr_pick | (right_oh[k] ? stops[k].color : '0);
         pr_pick   = pr_pick | (right_oh[k] ? stops[k].pos : '0);
         last_pick = last_pick | ((CNT_W'(k + 1) == n_sat) ? stops[k].color : '0);
      end
      for (int k = 0; k < MAX_STOPS - 1; k++) begin
         cl_pick = cl_pick | (right_oh[k+1] ? stops[k].color : '0);
         pl_pick = pl_pick | (right_oh[k+1] ? stops[k].pos : '0);
      end
   end

   always_comb begin
      seg_in.bypass = 1'b1;
      seg_in.p      = position;
      seg_in.pl     = pl_pick;
      seg_in.pr     = pr_pick;
      seg_in.cl     = cl_pick;
      seg_in.cr     = cr_pick;
      if (n_sat == '0) begin
         seg_in.cl = COLOR_BLACK;
      end else if (position <= stops[0].pos) begin
         seg_in.cl = stops[0].color;
      end else if (!found) begin
         seg_in.cl = last_pick;
      end else begin
         seg_in.bypass = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         seg_ff <= seg_in;
      end
   end

   assign seg_o = seg_ff;

endmodule

// File: rtl/gcl_scale.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Gradient scale stages
// Two stages: channel deltas and offsets, then delta times offset.
// ---------------------------------------------------------------------------
module gcl_scale (
   input  logic             clock,
   input  logic [1:0]       load,
   input  gcl_pkg::seg_type seg_i,
   output gcl_pkg::div_type div_o
);
   import gcl_pkg::*;

   prep_type prep_in;
   prep_type prep_ff;
   div_type  mul_in;
   div_type  mul_ff;

   always_comb begin
      prep_in.side.bypass = seg_i.bypass;
      prep_in.side.base   = seg_i.cl;
      prep_in.dp          = seg_i.p - seg_i.pl;
      prep_in.span        = seg_i.pr - seg_i.pl;
      for (int c = 0; c < NUM_CHAN; c++) begin
         prep_in.side.neg[c] = seg_i.cr[c] < seg_i.cl[c];
         prep_in.mag[c]      = prep_in.side.neg[c] ? (seg_i.cl[c] - seg_i.cr[c])
                                                   : (seg_i.cr[c] - seg_i.cl[c]);
      end
   end

   always_comb begin
      mul_in.side = prep_ff.side;
      mul_in.span = prep_ff.span;
      mul_in.quot = '0;
      for (int c = 0; c < NUM_CHAN; c++) begin
         mul_in.rem[c] = PROD_W'(prep_ff.mag[c]) * PROD_W'(prep_ff.dp);
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         prep_ff <= prep_in;
      end
      if (load[1]) begin
         mul_ff <= mul_in;
      end
   end

   assign div_o = mul_ff;

endmodule

// File: rtl/gcl_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Gradient divider
// Pipelined restoring divide of the four channel products by the segment
// span, a fixed number of quotient bits per stage.
// ---------------------------------------------------------------------------
module gcl_div (
   input  logic                               clock,
   input  logic [gcl_pkg::DIV_STAGES-1:0]     load,
   input  gcl_pkg::div_type                   div_i,
   output gcl_pkg::div_type                   div_o
);
   import gcl_pkg::*;

   div_type stg_in [DIV_STAGES];
   div_type stg_ff [DIV_STAGES];

   always_comb begin
      int       b;
      prod_type trial;
      for (int j = 0; j < DIV_STAGES; j++) begin
         stg_in[j] = (j == 0) ? div_i : stg_ff[(j == 0) ? 0 : j - 1];
         for (int c = 0; c < NUM_CHAN; c++) begin
            for (int s = 0; s < QUOT_STEPS; s++) begin
               b     = QUOT_W - 1 - j * QUOT_STEPS - s;
               trial = PROD_W'(stg_in[j].span) << b;
               if (stg_in[j].rem[c] >= trial) begin
                  stg_in[j].rem[c]     = stg_in[j].rem[c] - trial;
                  stg_in[j].quot[c][b] = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < DIV_STAGES; j++) begin
         if (load[j]) begin
            stg_ff[j] <= stg_in[j];
         end
      end
   end

   assign div_o = stg_ff[DIV_STAGES-1];

endmodule

// File: rtl/gradient_color_lookup_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Gradient color lookup
// Maps a 16-bit gradient position to a 12-bit-per-channel RGBA color from
// up to MAX_STOPS stops held in write-only registers.
// ---------------------------------------------------------------------------
// Accepts one position word per cycle while req_stall is low and returns one
// color word per position, in order. There are ten register stages (stop
// select, delta, multiply, six divider stages at two quotient bits each,
// final add into the output register), with rsp_valid from the last stage.
// Each stage advances whenever the stage after it is free, so bubbles
// collapse and a stalled output does not stop input until all ten stages
// hold a word. Register 0 holds the stop count, registers 1 to 7 the stops
// (position 63:48, red, green, blue, alpha at 12 bits each), written in
// ascending position order while the block is idle.
// ---------------------------------------------------------------------------
`include "gradient_color_lookup_top_defines.svh"

module gradient_color_lookup_top #(
   parameter int MAX_STOPS = 7
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [gcl_pkg::POS_W-1:0]         req_position,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [gcl_pkg::CHAN_W-1:0]        rsp_red,
   output logic [gcl_pkg::CHAN_W-1:0]        rsp_green,
   output logic [gcl_pkg::CHAN_W-1:0]        rsp_blue,
   output logic [gcl_pkg::CHAN_W-1:0]        rsp_alpha,
   input  logic                              csr_wen,
   input  logic [gcl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gcl_pkg::STOP_W-1:0]        csr_wdata
);
   import gcl_pkg::*;

   localparam int DIV_FIRST = 3;
   localparam int DIV_LAST  = NUM_STAGES - 2;

   logic [CNT_W-1:0]        stop_count_ff;
   stop_type [MAX_STOPS-1:0] stops_ff;

   logic [NUM_STAGES-1:0]   valid_ff;
   logic [NUM_STAGES-1:0]   valid_in;
   logic [NUM_STAGES-1:0]   ready;

   seg_type                 sel_seg;
   div_type                 scale_div;
   div_type                 div_out;
   color_type               out_in;
   color_type               out_ff;

   logic                    sel_blocked;
   logic                    div_rem_ok;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stop_count_ff <= '0;
         stops_ff      <= '0;
      end else if (csr_wen) begin
         if (csr_index == CSR_IDX_W'(REG_STOP_COUNT)) begin
            stop_count_ff <= csr_wdata[CNT_W-1:0];
         end
         for (int k = 0; k < MAX_STOPS; k++) begin
            if (csr_index == CSR_IDX_W'(REG_STOP_FIRST + k)) begin
               stops_ff[k] <= csr_wdata;
            end
         end
      end
   end

   // stage advance: a stage loads when it is empty or the next one loads
   always_comb begin
      ready[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
   end

   assign valid_in  = {valid_ff[NUM_STAGES-2:0], req_valid};
   assign req_stall = !ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NUM_STAGES; i++) begin
            if (ready[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   gcl_select #(
      .MAX_STOPS (MAX_STOPS)
   ) u_select (
      .clock      (clock),
      .load       (ready[0]),
      .position   (req_position),
      .stop_count (stop_count_ff),
      .stops      (stops_ff),
      .seg_o      (sel_seg)
   );

   gcl_scale u_scale (
      .clock (clock),
      .load  (ready[2:1]),
      .seg_i (sel_seg),
      .div_o (scale_div)
   );

   gcl_div u_div (
      .clock (clock),
      .load  (ready[DIV_LAST:DIV_FIRST]),
      .div_i (scale_div),
      .div_o (div_out)
   );

   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         out_in[c] = div_out.side.neg[c] ? (div_out.side.base[c] - div_out.quot[c])
                                         : (div_out.side.base[c] + div_out.quot[c]);
      end
      if (div_out.side.bypass) begin
         out_in = div_out.side.base;
      end
   end

   always_ff @(posedge clock) begin
      if (ready[NUM_STAGES-1]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = valid_ff[NUM_STAGES-1];
   assign rsp_red   = out_ff[CH_RED];
   assign rsp_green = out_ff[CH_GREEN];
   assign rsp_blue  = out_ff[CH_BLUE];
   assign rsp_alpha = out_ff[CH_ALPHA];

   assign sel_blocked = valid_ff[0] && !ready[0];

   always_comb begin
      div_rem_ok = 1'b1;
      for (int c = 0; c < NUM_CHAN; c++) begin
         if (div_out.rem[c] >= PROD_W'(div_out.span)) begin
            div_rem_ok = 1'b0;
         end
      end
   end

   `GCL_CHECK_NEXT(a_take_word, req_valid && !req_stall, valid_ff[0], "accepted word lost")
   `GCL_CHECK_NEXT(a_hold_select, sel_blocked, valid_ff[0] && $stable(sel_seg), "select moved")
   `GCL_CHECK_SAME(a_div_span, valid_ff[DIV_LAST] && !div_out.side.bypass, div_out.span != '0, "zero span")
   `GCL_CHECK_SAME(a_div_rem, valid_ff[DIV_LAST] && !div_out.side.bypass, div_rem_ok, "bad remainder")

endmodule
